// ===== rtl/ptw_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and descriptor helpers for the page table walker
// no dependencies

package ptw_pkg;

  // default physical address width
  localparam int PHYS_BITS_DEF = 48;

  // command codes of an input item
  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_RAW       = 2'd1;
  localparam logic [1:0] CMD_SETPROT   = 2'd2;
  localparam logic [1:0] CMD_RDATA     = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // walk level codes: idle, or waiting for the descriptor of L0..L3
  localparam logic [2:0] WL_IDLE = 3'd0;
  localparam logic [2:0] WL_L0   = 3'd1;
  localparam logic [2:0] WL_L1   = 3'd2;
  localparam logic [2:0] WL_L2   = 3'd3;
  localparam logic [2:0] WL_L3   = 3'd4;

  // descriptor bits
  localparam logic [63:0] D_VALID     = 64'h1;
  localparam logic [63:0] D_TABLE     = 64'h2;
  localparam logic [63:0] D_ATTR_DEV  = 64'h4;
  localparam logic [63:0] D_ATTR_MASK = 64'h1C;
  localparam logic [63:0] D_AP_USER   = 64'h40;
  localparam logic [63:0] D_SH_INNER  = 64'h300;
  localparam logic [63:0] D_AF        = 64'h400;
  localparam logic [63:0] D_XN        = 64'h0040_0000_0000_0000;

  // input item
  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] root_addr;
    logic [47:0] virt_addr;
    logic [5:0]  prot_flags;
    logic [63:0] mem_rdata;
  } ptw_item_t;

  // result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] mem_addr;
    logic [63:0] mem_wdata;
    logic [47:0] phys_addr;
    logic        status;
    logic        last;
  } ptw_result_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SECOND
  } ptw_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic eval;
    logic second;
  } ptw_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic pair;
  } ptw_stat_t;

  // leaf attribute bits built from the protection flags
  function automatic logic [63:0] leaf_attrs(logic [5:0] flags);
    logic [63:0] d;
    d = D_VALID | D_TABLE | D_AF | D_SH_INNER;
    if (flags[2]) d = d | D_AP_USER;
    if (flags[3]) d = d | D_XN;
    if (flags[4] || flags[5]) begin
      d = d & ~D_ATTR_MASK;
      d = d | D_ATTR_DEV;
      d = d & ~D_SH_INNER;
    end
    return d;
  endfunction

endpackage

// ===== rtl/ptw_ctrl.sv =====
`timescale 1ns / 1ps
// walker controller: sequences capture, evaluation and the second result
// depends on ptw_pkg

module ptw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ptw_pkg::ptw_stat_t  stat,
  output logic                busy,
  output ptw_pkg::ptw_ctrl_t  ctrl
);
  import ptw_pkg::*;

  ptw_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = stat.pair ? ST_SECOND : ST_IDLE;
      end
      ST_SECOND: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy         = 1'b1;
    ctrl.capture = 1'b0;
    ctrl.eval    = 1'b0;
    ctrl.second  = 1'b0;
    case (state)
      ST_IDLE: begin
        busy         = 1'b0;
        ctrl.capture = start;
      end
      ST_EVAL: begin
        ctrl.eval = 1'b1;
      end
      ST_SECOND: begin
        ctrl.second = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/ptw_datapath.sv =====
`timescale 1ns / 1ps
// walker datapath: item capture, walk state, descriptor decode, result register
// depends on ptw_pkg

module ptw_datapath #(
  parameter int PHYS_BITS = ptw_pkg::PHYS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptw_pkg::ptw_ctrl_t   ctrl,
  input  ptw_pkg::ptw_item_t   item,
  output ptw_pkg::ptw_stat_t   stat,
  output ptw_pkg::ptw_result_t result,
  output logic                 result_valid
);
  import ptw_pkg::*;

  localparam logic [63:0] PhysMask = (64'd1 << PHYS_BITS) - 64'd1;
  localparam logic [63:0] AddrMask = PhysMask & ~64'h0000_0000_0000_0FFF;
  localparam logic [63:0] GbMask   = PhysMask & ~64'h0000_0000_3FFF_FFFF;
  localparam logic [63:0] MbMask   = PhysMask & ~64'h0000_0000_001F_FFFF;

  // successful done that closes a leaf rewrite
  localparam ptw_result_t DoneOk = '{
    kind:      KIND_DONE,
    mem_addr:  48'd0,
    mem_wdata: 64'd0,
    phys_addr: 48'd0,
    status:    1'b0,
    last:      1'b1
  };

  // captured item
  ptw_item_t item_q;

  // walk state
  logic [2:0]  walk_level, walk_level_next;
  logic [1:0]  walk_op, walk_op_next;
  logic [47:0] saved_virt, saved_virt_next;
  logic [5:0]  saved_flags, saved_flags_next;
  logic [47:0] pending_addr, pending_addr_next;

  // evaluation results
  ptw_result_t res;
  logic        has_res;
  logic        pair;
  logic        idle;
  logic [63:0] e;
  logic [63:0] wide;
  logic [63:0] nd;
  logic [47:0] entry;

  // descriptor entry address for table level lvl
  function automatic logic [47:0] entry_addr(logic [63:0] base, logic [1:0] lvl,
                                             logic [47:0] va);
    logic [63:0] b;
    logic [8:0]  idx;
    b = base & AddrMask;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return {b[47:12], idx, 3'b000};
  endfunction

  // item capture
  always_ff @(posedge clk) begin
    if (ctrl.capture) item_q <= item;
  end

  // descriptor decode and walk step
  always_comb begin
    res               = '0;
    has_res           = 1'b0;
    pair              = 1'b0;
    walk_level_next   = walk_level;
    walk_op_next      = walk_op;
    saved_virt_next   = saved_virt;
    saved_flags_next  = saved_flags;
    pending_addr_next = pending_addr;
    e                 = item_q.mem_rdata;
    idle              = !(walk_level inside {[WL_L0:WL_L3]});
    wide              = '0;
    nd                = '0;
    entry             = '0;

    if (item_q.cmd != CMD_RDATA) begin
      // new request, taken only while no walk is in flight
      if (idle) begin
        walk_op_next      = item_q.cmd;
        saved_virt_next   = item_q.virt_addr;
        saved_flags_next  = item_q.prot_flags;
        entry             = entry_addr({16'd0, item_q.root_addr}, 2'd0, item_q.virt_addr);
        pending_addr_next = entry;
        walk_level_next   = WL_L0;
        has_res           = 1'b1;
        res.kind          = KIND_READ;
        res.mem_addr      = entry;
        res.last          = 1'b1;
      end
    end else if (!idle) begin
      has_res  = 1'b1;
      res.last = 1'b1;
      if (walk_level != WL_L3) begin
        // table levels L0..L2
        if (!e[0]) begin
          res.kind        = KIND_DONE;
          res.status      = 1'b1;
          walk_level_next = WL_IDLE;
        end else if (walk_level != WL_L0 && !e[1]) begin
          res.kind        = KIND_DONE;
          walk_level_next = WL_IDLE;
          if (walk_op == CMD_SETPROT) begin
            res.status = 1'b1;
          end else begin
            if (walk_level == WL_L1) begin
              wide = (e & GbMask) | {34'd0, saved_virt[29:0]};
            end else begin
              wide = (e & MbMask) | {43'd0, saved_virt[20:0]};
            end
            res.phys_addr = wide[47:0];
          end
        end else begin
          entry             = entry_addr(e, walk_level[1:0], saved_virt);
          pending_addr_next = entry;
          walk_level_next   = walk_level + 3'd1;
          res.kind          = KIND_READ;
          res.mem_addr      = entry;
        end
      end else begin
        // leaf level
        res.kind        = KIND_DONE;
        walk_level_next = WL_IDLE;
        wide            = (e & AddrMask) | {52'd0, saved_virt[11:0]};
        case (walk_op)
          CMD_TRANSLATE: begin
            if (!e[0]) res.status = 1'b1;
            else       res.phys_addr = wide[47:0];
          end
          CMD_RAW: begin
            if (e == 64'd0) res.status = 1'b1;
            else            res.phys_addr = wide[47:0];
          end
          default: begin
            if (e == 64'd0) begin
              res.status = (saved_flags != 6'd0);
            end else begin
              nd = e & AddrMask;
              if (saved_flags != 6'd0) nd = nd | leaf_attrs(saved_flags | 6'd1);
              res.kind      = KIND_WRITE;
              res.mem_addr  = pending_addr;
              res.mem_wdata = nd;
              res.last      = 1'b0;
              pair          = 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign stat.pair = pair;

  // walk state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_level   <= WL_IDLE;
      walk_op      <= CMD_TRANSLATE;
      saved_virt   <= '0;
      saved_flags  <= '0;
      pending_addr <= '0;
    end else if (ctrl.eval) begin
      walk_level   <= walk_level_next;
      walk_op      <= walk_op_next;
      saved_virt   <= saved_virt_next;
      saved_flags  <= saved_flags_next;
      pending_addr <= pending_addr_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (ctrl.eval && has_res) || ctrl.second;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      result <= res;
    end else if (ctrl.second) begin
      result <= DoneOk;
    end
  end

endmodule

// ===== rtl/four_level_page_table_walker_unit.sv =====
`timescale 1ns / 1ps
// flow: an accepted item is captured, then evaluated, and any result it yields is registered
// in the result register; a leaf rewrite adds a second, done result after its write result;
// busy holds off new items until the controller has returned to idle
// reset: synchronous rst returns the controller to idle and clears the walk state
// results are single-cycle strobes; the receiver cannot stall

module four_level_page_table_walker_unit #(
  parameter int PHYS_BITS = ptw_pkg::PHYS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ptw_pkg::ptw_item_t   item,
  output logic                 busy,
  output ptw_pkg::ptw_result_t result,
  output logic                 result_valid
);
  import ptw_pkg::*;

  ptw_ctrl_t ctrl;
  ptw_stat_t stat;

  // controller
  ptw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // datapath
  ptw_datapath #(
    .PHYS_BITS (PHYS_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .item         (item),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ===== rtl/ptw_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the page table walker, bound to the top level
// depends on ptw_pkg and four_level_page_table_walker_unit

module ptw_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input ptw_pkg::ptw_result_t result,
  input logic                 result_valid
);
  import ptw_pkg::*;

  // an accepted item keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("unit not busy after transfer");

  // a non-final result is followed at once by another result
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |=> (result_valid && result.last))
    else $error("second result missing");

  // a write result is never the final one and the final one after it is a done
  a_write_not_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_WRITE) |=>
      (result.kind == KIND_DONE && result.status == 1'b0))
    else $error("write not followed by successful done");

  // a fault is only reported on done with a zero address
  a_fault_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status) |->
      (result.kind == KIND_DONE && result.phys_addr == 48'd0))
    else $error("fault on non-done result or with address");

endmodule

bind four_level_page_table_walker_unit ptw_checker u_ptw_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result       (result),
  .result_valid (result_valid)
);
